// ===== rtl/cdsd_pkg.sv =====
// Package for the calendar date shift and distance block: field widths,
// calendar constants, command and result structs, and calendar helper functions.
// No dependencies.
package cdsd_pkg;

    localparam int OFFSET_BITS_DEF = 21;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int SER_W  = 22;  // serial day number, 1/1/1 = 0
    localparam int DIST_W = 23;
    localparam int REM_W  = 9;   // day within a year

    // Input word: fixed fields around the offset; result word: 46 field bits.
    localparam int IN_FIXED_BITS  = 46;
    localparam int OUT_FIELD_BITS = 46;
    localparam int OUT_DATA_W     = 48;

    localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
    localparam logic [MON_W-1:0]  MON_LAST   = 4'd12;
    localparam logic [SER_W-1:0]  LAST_SERIAL = 22'd3652058;

    // floor(y / 100) = (y * 5243) >> 19 for every y below 2^14
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    // year estimate: serial * 2871 >> 20 is serial / 365.2425 to within a year
    localparam int EST_MUL   = 2871;
    localparam int EST_SHIFT = 20;

    typedef struct packed {
        logic              kind;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  other_day;
        logic [MON_W-1:0]  other_month;
        logic [YEAR_W-1:0] other_year;
    } cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]         day;
        logic [MON_W-1:0]         month;
        logic [YEAR_W-1:0]        year;
        logic signed [DIST_W-1:0] distance;
        logic                     replaced;
        logic                     saturated;
    } res_t;

    // Years divisible by 4, except centuries not divisible by 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [YEAR_W-1:0] back;
        logic        cent;
        prod = 27'(y) * 27'(DIV100_MUL);
        q    = prod[DIV100_SHIFT +: 8];
        back = YEAR_W'({q, 6'b0}) + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0});
        cent = (back == y);
        return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd2:                                    n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                 n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            default:                                 n = 5'd0;
        endcase
        return n;
    endfunction

    // Days from the first of January up to the first of month m.
    function automatic logic [REM_W-1:0] days_before_month(input logic [MON_W-1:0] m,
                                                           input logic leap);
        logic [REM_W-1:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n + REM_W'(leap && (m > 4'd2));
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                     input logic [MON_W-1:0] m,
                                     input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] dim;
        dim = days_in_month(m, is_leap(y));
        return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (d != 5'd0) && (d <= dim);
    endfunction

endpackage

// ===== rtl/cdsd_ybase.sv =====
// Shared year-base unit: days from 1/1/1 up to 1/1/year.
// Depends on cdsd_pkg.
module cdsd_ybase (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cdsd_pkg::YEAR_W-1:0]   year,
    output logic                          done,
    output logic [cdsd_pkg::SER_W-1:0]    dby
);

    logic [cdsd_pkg::YEAR_W-1:0] p;
    logic [26:0]                 prod100;
    logic                        v1_reg;
    logic                        v2_reg;
    logic [cdsd_pkg::SER_W-1:0]  p365_reg;
    logic [11:0]                 p4_reg;
    logic [7:0]                  q100_reg;
    logic [cdsd_pkg::SER_W-1:0]  dby_reg;

    assign p       = year - cdsd_pkg::YEAR_MIN;
    assign prod100 = 27'(p) * 27'(cdsd_pkg::DIV100_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: 365 * p and p / 100; stage 2: add leap days
    always_ff @(posedge aclk) begin
        p365_reg <= cdsd_pkg::SER_W'(p) * cdsd_pkg::SER_W'(365);
        p4_reg   <= p[cdsd_pkg::YEAR_W-1:2];
        q100_reg <= prod100[cdsd_pkg::DIV100_SHIFT +: 8];
        dby_reg  <= p365_reg + cdsd_pkg::SER_W'(p4_reg) - cdsd_pkg::SER_W'(q100_reg)
                    + cdsd_pkg::SER_W'(q100_reg[7:2]);
    end

    assign done = v2_reg;
    assign dby  = dby_reg;

endmodule

// ===== rtl/cdsd_seq.sv =====
// Sequencer and accumulator datapath: validates dates, builds serial day numbers,
// applies the shift, and searches year and month back out. Depends on cdsd_pkg.
module cdsd_seq #(
    parameter int OFFSET_BITS = cdsd_pkg::OFFSET_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  cdsd_pkg::cmd_t                     cmd,
    input  logic signed [OFFSET_BITS-1:0]      offset,
    output logic                               idle,
    output logic                               res_valid,
    input  logic                               res_free,
    output cdsd_pkg::res_t                     res,
    output logic                               yb_start,
    output logic [cdsd_pkg::YEAR_W-1:0]        yb_year,
    input  logic                               yb_done,
    input  logic [cdsd_pkg::SER_W-1:0]         yb_dby
);

    localparam int TW = ((OFFSET_BITS > cdsd_pkg::SER_W + 1) ?
                         OFFSET_BITS : cdsd_pkg::SER_W + 1) + 1;
    localparam int SW = cdsd_pkg::SER_W;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CHECK = 11'b00000000010,
        ST_BASE1 = 11'b00000000100,
        ST_BASE2 = 11'b00000001000,
        ST_SHIFT = 11'b00000010000,
        ST_EST   = 11'b00000100000,
        ST_YLOW  = 11'b00001000000,
        ST_YHIGH = 11'b00010000000,
        ST_MSET  = 11'b00100000000,
        ST_MON   = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } state_t;

    state_t st_reg, st_next;

    logic                                 kind_reg, kind_next;
    logic [cdsd_pkg::DAY_W-1:0]           d1_reg, d1_next, d2_reg, d2_next;
    logic [cdsd_pkg::MON_W-1:0]           m1_reg, m1_next, m2_reg, m2_next;
    logic [cdsd_pkg::YEAR_W-1:0]          y1_reg, y1_next, y2_reg, y2_next;
    logic                                 lp1_reg, lp1_next, lp2_reg, lp2_next;
    logic                                 lpy_reg, lpy_next;
    logic signed [OFFSET_BITS-1:0]        off_reg, off_next;
    logic                                 replaced_reg, replaced_next;
    logic                                 sat_reg, sat_next;
    logic [SW-1:0]                        ser_reg, ser_next;
    logic [SW-1:0]                        base_reg, base_next;
    logic signed [cdsd_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [cdsd_pkg::YEAR_W-1:0]          yy_reg, yy_next;
    logic [cdsd_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic [cdsd_pkg::MON_W-1:0]           mm_reg, mm_next;

    logic                                 ok1, ok2;
    logic [SW-1:0]                        ser1_sum, ser2_sum;
    logic [TW-1:0]                        t_sum;
    logic                                 t_over;
    logic [33:0]                          est_prod;
    logic [cdsd_pkg::YEAR_W:0]            est_yy;
    logic [cdsd_pkg::DAY_W-1:0]           dim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        d1_reg       <= d1_next;
        m1_reg       <= m1_next;
        y1_reg       <= y1_next;
        d2_reg       <= d2_next;
        m2_reg       <= m2_next;
        y2_reg       <= y2_next;
        lp1_reg      <= lp1_next;
        lp2_reg      <= lp2_next;
        lpy_reg      <= lpy_next;
        off_reg      <= off_next;
        replaced_reg <= replaced_next;
        sat_reg      <= sat_next;
        ser_reg      <= ser_next;
        base_reg     <= base_next;
        dist_reg     <= dist_next;
        yy_reg       <= yy_next;
        rem_reg      <= rem_next;
        mm_reg       <= mm_next;
    end

    always_comb begin
        st_next       = st_reg;
        kind_next     = kind_reg;
        d1_next       = d1_reg;
        m1_next       = m1_reg;
        y1_next       = y1_reg;
        d2_next       = d2_reg;
        m2_next       = m2_reg;
        y2_next       = y2_reg;
        lp1_next      = lp1_reg;
        lp2_next      = lp2_reg;
        lpy_next      = lpy_reg;
        off_next      = off_reg;
        replaced_next = replaced_reg;
        sat_next      = sat_reg;
        ser_next      = ser_reg;
        base_next     = base_reg;
        dist_next     = dist_reg;
        yy_next       = yy_reg;
        rem_next      = rem_reg;
        mm_next       = mm_reg;
        yb_start      = 1'b0;
        yb_year       = yy_reg;

        ok1      = cdsd_pkg::date_ok(d1_reg, m1_reg, y1_reg);
        ok2      = cdsd_pkg::date_ok(d2_reg, m2_reg, y2_reg);
        ser1_sum = yb_dby + SW'(cdsd_pkg::days_before_month(m1_reg, lp1_reg))
                   + SW'(d1_reg) - SW'(1);
        ser2_sum = yb_dby + SW'(cdsd_pkg::days_before_month(m2_reg, lp2_reg))
                   + SW'(d2_reg) - SW'(1);
        t_sum    = TW'({1'b0, ser_reg}) + TW'(off_reg);
        t_over   = !t_sum[TW-1] && (t_sum[TW-2:0] > (TW-1)'(cdsd_pkg::LAST_SERIAL));
        est_prod = 34'(ser_reg) * 34'(cdsd_pkg::EST_MUL);
        est_yy   = (cdsd_pkg::YEAR_W+1)'(est_prod[cdsd_pkg::EST_SHIFT +: cdsd_pkg::YEAR_W])
                   + (cdsd_pkg::YEAR_W+1)'(1);
        dim      = cdsd_pkg::days_in_month(mm_reg, lpy_reg);

        unique case (st_reg)
            ST_IDLE: begin
                if (start) begin
                    kind_next = cmd.kind;
                    d1_next   = cmd.day;
                    m1_next   = cmd.month;
                    y1_next   = cmd.year;
                    d2_next   = cmd.other_day;
                    m2_next   = cmd.other_month;
                    y2_next   = cmd.other_year;
                    off_next  = offset;
                    st_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // replace a bad date by 1/1/1970, which is not a leap year
                d1_next       = ok1 ? d1_reg : 5'd1;
                m1_next       = ok1 ? m1_reg : 4'd1;
                y1_next       = ok1 ? y1_reg : cdsd_pkg::EPOCH_YEAR;
                d2_next       = ok2 ? d2_reg : 5'd1;
                m2_next       = ok2 ? m2_reg : 4'd1;
                y2_next       = ok2 ? y2_reg : cdsd_pkg::EPOCH_YEAR;
                lp1_next      = ok1 && cdsd_pkg::is_leap(y1_reg);
                lp2_next      = ok2 && cdsd_pkg::is_leap(y2_reg);
                replaced_next = !ok1 || (kind_reg && !ok2);
                sat_next      = 1'b0;
                dist_next     = '0;
                yb_start      = 1'b1;
                yb_year       = y1_next;
                st_next       = ST_BASE1;
            end
            ST_BASE1: begin
                if (yb_done) begin
                    ser_next = ser1_sum;
                    if (kind_reg) begin
                        yb_start = 1'b1;
                        yb_year  = y2_reg;
                        st_next  = ST_BASE2;
                    end else begin
                        st_next = ST_SHIFT;
                    end
                end
            end
            ST_BASE2: begin
                if (yb_done) begin
                    dist_next = cdsd_pkg::DIST_W'({1'b0, ser_reg})
                                - cdsd_pkg::DIST_W'({1'b0, ser2_sum});
                    st_next   = ST_DONE;
                end
            end
            ST_SHIFT: begin
                // clamp to 1/1/1 .. 31/12/9999
                priority if (t_sum[TW-1]) begin
                    ser_next = '0;
                    sat_next = 1'b1;
                end else if (t_over) begin
                    ser_next = cdsd_pkg::LAST_SERIAL;
                    sat_next = 1'b1;
                end else begin
                    ser_next = t_sum[SW-1:0];
                end
                st_next = ST_EST;
            end
            ST_EST: begin
                yy_next  = (est_yy > (cdsd_pkg::YEAR_W+1)'(cdsd_pkg::YEAR_MAX)) ?
                           cdsd_pkg::YEAR_MAX : est_yy[cdsd_pkg::YEAR_W-1:0];
                yb_start = 1'b1;
                yb_year  = yy_next;
                st_next  = ST_YLOW;
            end
            ST_YLOW: begin
                // step down while the year starts after the serial
                if (yb_done) begin
                    if ((yb_dby > ser_reg) && (yy_reg > cdsd_pkg::YEAR_MIN)) begin
                        yy_next  = yy_reg - 14'd1;
                        yb_start = 1'b1;
                        yb_year  = yy_next;
                    end else begin
                        base_next = yb_dby;
                        if (yy_reg == cdsd_pkg::YEAR_MAX) begin
                            st_next = ST_MSET;
                        end else begin
                            yb_start = 1'b1;
                            yb_year  = yy_reg + 14'd1;
                            st_next  = ST_YHIGH;
                        end
                    end
                end
            end
            ST_YHIGH: begin
                // step up while the next year still starts at or before the serial
                if (yb_done) begin
                    if (yb_dby <= ser_reg) begin
                        yy_next   = yy_reg + 14'd1;
                        base_next = yb_dby;
                        if (yy_next == cdsd_pkg::YEAR_MAX) begin
                            st_next = ST_MSET;
                        end else begin
                            yb_start = 1'b1;
                            yb_year  = yy_reg + 14'd2;
                        end
                    end else begin
                        st_next = ST_MSET;
                    end
                end
            end
            ST_MSET: begin
                rem_next = cdsd_pkg::REM_W'(ser_reg - base_reg);
                lpy_next = cdsd_pkg::is_leap(yy_reg);
                mm_next  = 4'd1;
                st_next  = ST_MON;
            end
            ST_MON: begin
                // walk one month per cycle
                if ((mm_reg < cdsd_pkg::MON_LAST) &&
                    (rem_reg >= cdsd_pkg::REM_W'(dim))) begin
                    rem_next = rem_reg - cdsd_pkg::REM_W'(dim);
                    mm_next  = mm_reg + 4'd1;
                end else begin
                    d1_next = cdsd_pkg::DAY_W'(rem_reg + 9'd1);
                    m1_next = mm_reg;
                    y1_next = yy_reg;
                    st_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign idle          = (st_reg == ST_IDLE);
    assign res_valid     = (st_reg == ST_DONE);
    assign res.day       = d1_reg;
    assign res.month     = m1_reg;
    assign res.year      = y1_reg;
    assign res.distance  = dist_reg;
    assign res.replaced  = replaced_reg;
    assign res.saturated = sat_reg;

endmodule

// ===== rtl/calendar_date_shift_and_distance.sv =====
// Top level of the Gregorian date shift and day distance block: stream ports,
// word unpacking and the result register. Depends on cdsd_pkg, cdsd_ybase, cdsd_seq.
//
// Usage
//   Slave channel (s_*): one word per request. s_tuser carries the kind:
//   0 shifts the first date by the signed offset, 1 gives the day distance
//   first date minus second date. Bad dates are replaced by 1/1/1970 and
//   flagged in m_tuser[0]. A shift that would leave 1/1/1..31/12/9999 is
//   clamped and flagged in m_tuser[1].
//   Master channel (m_*): one result word per request, in request order.
// Timing
//   The block takes one request at a time; s_tready is high only while the
//   sequencer is idle. A distance request probes the shared year-base unit
//   for the serial of each date. A shift probes it for the serial of the
//   date, then one to three times around the year estimate, and then
//   walks the months in order, one step per month passed.
// Reset and stall
//   aresetn (synchronous, active low) returns the sequencer to idle and
//   drops m_tvalid. A finished result sits in the output register while the
//   receiver stalls; the next request is accepted meanwhile and holds in its
//   final state until the output register frees.
module calendar_date_shift_and_distance #(
    parameter int OFFSET_BITS = cdsd_pkg::OFFSET_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // request channel
    input  logic s_tvalid,
    output logic s_tready,
    // day[4:0], month[8:5], year[22:9], offset, other_day, other_month, other_year
    input  logic [((cdsd_pkg::IN_FIXED_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // kind
    input  logic s_tuser,
    // result channel
    output logic m_tvalid,
    input  logic m_tready,
    // result_day[4:0], result_month[8:5], result_year[22:9], distance[45:23]
    output logic [cdsd_pkg::OUT_DATA_W-1:0] m_tdata,
    // input_replaced[0], saturated[1]
    output logic [1:0] m_tuser
);

    localparam int OFF_LSB = cdsd_pkg::DAY_W + cdsd_pkg::MON_W + cdsd_pkg::YEAR_W;
    localparam int OD_LSB  = OFF_LSB + OFFSET_BITS;
    localparam int OM_LSB  = OD_LSB + cdsd_pkg::DAY_W;
    localparam int OY_LSB  = OM_LSB + cdsd_pkg::MON_W;
    localparam int PAD_W   = cdsd_pkg::OUT_DATA_W - cdsd_pkg::OUT_FIELD_BITS;

    cdsd_pkg::cmd_t                 cmd;
    cdsd_pkg::res_t                 res;
    logic signed [OFFSET_BITS-1:0]  offset;
    logic                           start;
    logic                           idle;
    logic                           res_valid;
    logic                           res_free;
    logic                           load;
    logic                           yb_start;
    logic [cdsd_pkg::YEAR_W-1:0]    yb_year;
    logic                           yb_done;
    logic [cdsd_pkg::SER_W-1:0]     yb_dby;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [cdsd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]                     m_tuser_reg;

    // Unpack the request word.
    assign cmd.kind        = s_tuser;
    assign cmd.day         = s_tdata[0 +: cdsd_pkg::DAY_W];
    assign cmd.month       = s_tdata[cdsd_pkg::DAY_W +: cdsd_pkg::MON_W];
    assign cmd.year        = s_tdata[cdsd_pkg::DAY_W + cdsd_pkg::MON_W +: cdsd_pkg::YEAR_W];
    assign offset          = s_tdata[OFF_LSB +: OFFSET_BITS];
    assign cmd.other_day   = s_tdata[OD_LSB +: cdsd_pkg::DAY_W];
    assign cmd.other_month = s_tdata[OM_LSB +: cdsd_pkg::MON_W];
    assign cmd.other_year  = s_tdata[OY_LSB +: cdsd_pkg::YEAR_W];

    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    cdsd_ybase u_ybase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (yb_start),
        .year    (yb_year),
        .done    (yb_done),
        .dby     (yb_dby)
    );

    cdsd_seq #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .offset    (offset),
        .idle      (idle),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res),
        .yb_start  (yb_start),
        .yb_year   (yb_year),
        .yb_done   (yb_done),
        .yb_dby    (yb_dby)
    );

    // Output register: free when empty or being drained this cycle.
    assign res_free = !m_tvalid_reg || m_tready;
    assign load     = res_valid && res_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the payload while stalled; load a new word only when free.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res.distance, res.year, res.month, res.day};
            m_tuser_reg <= {res.saturated, res.replaced};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/cdsd_checker.sv =====
// Port-level checks for the calendar date shift and distance block, bound to
// its top level. Depends on calendar_date_shift_and_distance.
module cdsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One request at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // Every result has a month from 1 to 12 and a nonzero day.
    a_valid_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12) &&
                     (m_tdata[4:0] != 5'd0))
        else $error("result date out of range");

    // Saturation only comes from a shift, which reports zero distance.
    a_sat_no_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[45:23] == 23'd0))
        else $error("saturated result with nonzero distance");

    // Reset drops the result channel.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind calendar_date_shift_and_distance cdsd_checker u_cdsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
